// ===== hdl/two_voice_tone_sequencer_defines.svh =====
// assertion macros for the two-voice tone sequencer
// used by two_voice_tone_sequencer.sv; expects clk and rst_n in scope
`ifndef TWO_VOICE_TONE_SEQUENCER_DEFINES_SVH
`define TWO_VOICE_TONE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

`define TVTS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tvts assertion failed");

`define TVTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvts assertion failed");

`else

`define TVTS_ASSERT_NEVER(lbl, cond)

`define TVTS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/tvts_pkg.sv =====
// shared constants, codes, types and the phase step table
// of the two-voice tone sequencer; no dependencies
`default_nettype none

package tvts_pkg;

    localparam int SEQ_DEPTH  = 128;
    localparam int POS_W      = $clog2(SEQ_DEPTH);

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 7;
    localparam int NOTE_W     = 6;
    localparam int LEN_W      = 8;
    localparam int TICK_W     = 16;
    localparam int PHASE_W    = 16;
    localparam int SAMPLE_W   = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int EXT_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam int AX_W   = ((POS_W > ADDR_W) ? POS_W : ADDR_W) + 1;
    localparam int DVD_W  = POS_W + 1;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    // phase / 400 as ((phase >> 4) * 2622) >> 16, exact for 16-bit phase
    localparam int DIV_PRE  = 4;
    localparam int DIV_MUL  = 2622;
    localparam int DIV_POST = 16;
    localparam int DQ_W     = PHASE_W - DIV_PRE;
    localparam int MUL_W    = 12;
    localparam int PROD_W   = DQ_W + MUL_W;
    localparam int QUO_W    = SAMPLE_W - 1;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR1  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR2  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_V1_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V2_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V1_LONG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V1_SHORT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_V2_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_V1_TRANS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_V2_TRANS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd7;

    localparam logic [LEN_W-1:0]   V1_LEN_RST   = 8'd101;
    localparam logic [LEN_W-1:0]   V2_LEN_RST   = 8'd7;
    localparam logic [TICK_W-1:0]  V1_LONG_RST  = 16'd20000;
    localparam logic [TICK_W-1:0]  V1_SHORT_RST = 16'd10000;
    localparam logic [TICK_W-1:0]  V2_TICKS_RST = 16'd40000;
    localparam logic [NOTE_W-1:0]  V1_TRANS_RST = 6'd24;
    localparam logic [NOTE_W-1:0]  V2_TRANS_RST = 6'd12;
    localparam logic [PHASE_W-1:0] THRESH_RST   = 16'd32000;
    localparam logic [TICK_W-1:0]  REMAIN_RST   = 16'd20000;

    localparam int STEP_COUNT = 48;

    localparam logic [PHASE_W-1:0] STEP_TABLE [STEP_COUNT] = '{
        16'd163,  16'd173,  16'd183,  16'd194,  16'd206,  16'd218,
        16'd231,  16'd245,  16'd259,  16'd275,  16'd291,  16'd309,
        16'd327,  16'd346,  16'd367,  16'd389,  16'd412,  16'd436,
        16'd462,  16'd490,  16'd519,  16'd550,  16'd583,  16'd617,
        16'd654,  16'd693,  16'd734,  16'd778,  16'd824,  16'd873,
        16'd925,  16'd980,  16'd1038, 16'd1100, 16'd1165, 16'd1234,
        16'd1308, 16'd1386, 16'd1468, 16'd1555, 16'd1648, 16'd1746,
        16'd1849, 16'd1959, 16'd2076, 16'd2199, 16'd2330, 16'd2469
    };

    typedef struct packed {
        logic              tick;
        logic              wr_en;
        logic [POS_W-1:0]  wr_addr;
        logic [NOTE_W-1:0] wr_note;
    } tvts_voice_ctl_t;

    typedef struct packed {
        logic              len_load;
        logic [LEN_W-1:0]  length;
        logic [NOTE_W-1:0] transpose;
        logic [TICK_W-1:0] reload;
    } tvts_voice_cfg_t;

    // out-of-table index gives a zero step
    function automatic logic [PHASE_W-1:0] step_lookup(input logic [NOTE_W-1:0] idx);
        logic [PHASE_W-1:0] res;
        res = '0;
        if (int'(idx) < STEP_COUNT)
        begin
            res = STEP_TABLE[idx];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tvts_voice.sv =====
// one voice: note memory, play position, phase accumulator, length counter
// and a bit-serial remainder unit for the wrap position; uses tvts_pkg
`default_nettype none

module tvts_voice
    import tvts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tvts_voice_ctl_t    ctl,
    input  tvts_voice_cfg_t    cfg,
    output logic [PHASE_W-1:0] phase_next,
    output logic               busy
);

    logic [NOTE_W-1:0]  mem [SEQ_DEPTH];
    logic [NOTE_W-1:0]  mem_q;
    logic               byp_vld_reg;
    logic [NOTE_W-1:0]  byp_note_reg;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   nxt_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [TICK_W-1:0]  remain_reg;

    logic [DCNT_W-1:0]  dcnt_reg;
    logic [LEN_W-1:0]   drem_reg;
    logic [DVD_W-1:0]   ddvd_reg;

    logic [NOTE_W-1:0]  note_cur;
    logic [NOTE_W:0]    diff;
    logic [PHASE_W-1:0] step;
    logic [PHASE_W-1:0] phase_sum;
    logic [TICK_W-1:0]  remain_dec;
    logic               hit;
    logic               adv;
    logic [EXT_W-1:0]   wrap_m;
    logic [POS_W-1:0]   wrap_nxt;
    logic [POS_W-1:0]   rd_addr;
    logic [LEN_W:0]     dsh;
    logic [LEN_W:0]     dlen;
    logic [LEN_W:0]     dsub;
    logic [LEN_W-1:0]   drem_new;
    logic [EXT_W-1:0]   dres_x;
    logic [POS_W-1:0]   div_nxt;
    logic [DVD_W-1:0]   dstart_dvd;

    always_comb
    begin
        note_cur   = byp_vld_reg ? byp_note_reg : mem_q;
        diff       = {1'b0, note_cur} - {1'b0, cfg.transpose};
        step       = diff[NOTE_W] ? '0 : step_lookup(diff[NOTE_W-1:0]);
        phase_sum  = phase_reg + step;
        remain_dec = remain_reg - TICK_W'(1);
        hit        = (remain_dec == '0);
        adv        = ctl.tick & hit;
        phase_next = hit ? '0 : phase_sum;

        // position after the current one is already below the length
        wrap_m   = EXT_W'(nxt_reg) + EXT_W'(1);
        wrap_nxt = POS_W'(wrap_m);
        if ((cfg.length == '0) || (wrap_m >= EXT_W'(cfg.length))
            || (wrap_m >= EXT_W'(SEQ_DEPTH)))
        begin
            wrap_nxt = '0;
        end

        rd_addr = adv ? nxt_reg : pos_reg;
        busy    = (dcnt_reg != '0);

        // restoring remainder of (pos + 1) by the length, one bit a cycle
        dsh      = {drem_reg, ddvd_reg[DVD_W-1]};
        dlen     = {1'b0, cfg.length};
        dsub     = dsh - dlen;
        drem_new = (dsh >= dlen) ? dsub[LEN_W-1:0] : dsh[LEN_W-1:0];
        dres_x   = EXT_W'(drem_new);
        div_nxt  = POS_W'(dres_x);
        if ((cfg.length == '0) || (dres_x >= EXT_W'(SEQ_DEPTH)))
        begin
            div_nxt = '0;
        end
        dstart_dvd = DVD_W'(pos_reg) + DVD_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_note;
        end
        mem_q        <= mem[rd_addr];
        byp_note_reg <= ctl.wr_note;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_vld_reg <= 1'b0;
            pos_reg     <= '0;
            nxt_reg     <= '0;
            phase_reg   <= '0;
            remain_reg  <= REMAIN_RST;
            dcnt_reg    <= DCNT_W'(DVD_W);
            drem_reg    <= '0;
            ddvd_reg    <= DVD_W'(1);
        end
        else
        begin
            // write landing on the entry being read
            byp_vld_reg <= ctl.wr_en && (ctl.wr_addr == rd_addr);
            if (ctl.tick)
            begin
                phase_reg  <= phase_next;
                remain_reg <= hit ? cfg.reload : remain_dec;
                if (hit)
                begin
                    pos_reg <= nxt_reg;
                    nxt_reg <= wrap_nxt;
                end
            end
            if (cfg.len_load)
            begin
                dcnt_reg <= DCNT_W'(DVD_W);
                drem_reg <= '0;
                ddvd_reg <= dstart_dvd;
            end
            else if (busy)
            begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
                drem_reg <= drem_new;
                ddvd_reg <= ddvd_reg << 1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    nxt_reg <= div_nxt;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/two_voice_tone_sequencer.sv =====
// top level of the two-voice tone sequencer: config registers, command
// decode, two voices, sample scaling and output register; uses tvts_pkg,
// tvts_voice and two_voice_tone_sequencer_defines.svh
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------
//  in      | in_valid / in_ready  | cmd, addr, note, long_pick
//  out     | out_valid / out_ready| sample
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one request per cycle while in_ready is high; a tick fills the pending stage
// (voice update), then the scaling multiply writes the output register
// the note memories are read every cycle at the play position, or the next
// one when it advances; after reset and after each length write, in_ready
// stays low while the wrap position is recomputed bit-serially; otherwise it
// drops only when the pending stage and output register are full and stalled
`default_nettype none
`include "two_voice_tone_sequencer_defines.svh"

module two_voice_tone_sequencer
    import tvts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [NOTE_W-1:0]     note,
    input  logic                  long_pick,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   sample,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LEN_W-1:0]   v1_len_reg;
    logic [LEN_W-1:0]   v2_len_reg;
    logic [TICK_W-1:0]  v1_long_reg;
    logic [TICK_W-1:0]  v1_short_reg;
    logic [TICK_W-1:0]  v2_ticks_reg;
    logic [NOTE_W-1:0]  v1_trans_reg;
    logic [NOTE_W-1:0]  v2_trans_reg;
    logic [PHASE_W-1:0] thresh_reg;

    logic               s2_vld_reg;
    logic [PHASE_W-1:0] s2_phase_reg;
    logic               s2_high_reg;
    logic               out_vld_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic               cfg_acc;
    logic               in_acc;
    logic               tick_acc;
    logic               s2_move;
    logic [AX_W-1:0]    addr_x;
    logic               addr_ok;
    logic [POS_W-1:0]   wr_addr;
    logic               v1_busy;
    logic               v2_busy;
    logic [PHASE_W-1:0] v1_phase;
    logic [PHASE_W-1:0] v2_phase;
    logic [DQ_W-1:0]    dq;
    logic [PROD_W-1:0]  prod;
    logic [QUO_W-1:0]   quo;

    tvts_voice_ctl_t    v1_ctl;
    tvts_voice_ctl_t    v2_ctl;
    tvts_voice_cfg_t    v1_cfg;
    tvts_voice_cfg_t    v2_cfg;

    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_acc   = cfg_valid & cfg_ready;

        s2_move  = s2_vld_reg & (~out_vld_reg | out_ready);
        in_ready = ~v1_busy & ~v2_busy & (~s2_vld_reg | s2_move);
        in_acc   = in_valid & in_ready;
        tick_acc = in_acc & (cmd == CMD_TICK);

        addr_x  = AX_W'(addr);
        addr_ok = (addr_x < AX_W'(SEQ_DEPTH));
        wr_addr = POS_W'(addr_x);

        v1_ctl.tick    = tick_acc;
        v1_ctl.wr_en   = in_acc & (cmd == CMD_WR1) & addr_ok;
        v1_ctl.wr_addr = wr_addr;
        v1_ctl.wr_note = note;
        v2_ctl.tick    = tick_acc;
        v2_ctl.wr_en   = in_acc & (cmd == CMD_WR2) & addr_ok;
        v2_ctl.wr_addr = wr_addr;
        v2_ctl.wr_note = note;

        v1_cfg.len_load  = cfg_acc & (cfg_index == REG_V1_LEN);
        v1_cfg.length    = v1_len_reg;
        v1_cfg.transpose = v1_trans_reg;
        v1_cfg.reload    = long_pick ? v1_long_reg : v1_short_reg;
        v2_cfg.len_load  = cfg_acc & (cfg_index == REG_V2_LEN);
        v2_cfg.length    = v2_len_reg;
        v2_cfg.transpose = v2_trans_reg;
        v2_cfg.reload    = v2_ticks_reg;

        dq   = s2_phase_reg[PHASE_W-1:DIV_PRE];
        prod = PROD_W'(dq) * PROD_W'(DIV_MUL);
        quo  = QUO_W'(prod >> DIV_POST);

        out_valid = out_vld_reg;
        sample    = sample_reg;
    end

    tvts_voice u_voice1 (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (v1_ctl),
        .cfg        (v1_cfg),
        .phase_next (v1_phase),
        .busy       (v1_busy)
    );

    tvts_voice u_voice2 (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (v2_ctl),
        .cfg        (v2_cfg),
        .phase_next (v2_phase),
        .busy       (v2_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_len_reg   <= V1_LEN_RST;
            v2_len_reg   <= V2_LEN_RST;
            v1_long_reg  <= V1_LONG_RST;
            v1_short_reg <= V1_SHORT_RST;
            v2_ticks_reg <= V2_TICKS_RST;
            v1_trans_reg <= V1_TRANS_RST;
            v2_trans_reg <= V2_TRANS_RST;
            thresh_reg   <= THRESH_RST;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                REG_V1_LEN:   v1_len_reg   <= cfg_data[LEN_W-1:0];
                REG_V2_LEN:   v2_len_reg   <= cfg_data[LEN_W-1:0];
                REG_V1_LONG:  v1_long_reg  <= cfg_data[TICK_W-1:0];
                REG_V1_SHORT: v1_short_reg <= cfg_data[TICK_W-1:0];
                REG_V2_TICKS: v2_ticks_reg <= cfg_data[TICK_W-1:0];
                REG_V1_TRANS: v1_trans_reg <= cfg_data[NOTE_W-1:0];
                REG_V2_TRANS: v2_trans_reg <= cfg_data[NOTE_W-1:0];
                REG_THRESH:   thresh_reg   <= cfg_data[PHASE_W-1:0];
                default:      thresh_reg   <= thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (tick_acc)
            begin
                s2_vld_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_vld_reg <= 1'b0;
            end
            if (s2_move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s2_phase_reg <= v1_phase;
            s2_high_reg  <= (v2_phase > thresh_reg);
        end
        if (s2_move)
        begin
            sample_reg <= {s2_high_reg, quo};
        end
    end

    `TVTS_ASSERT_NEVER(a_no_overrun, tick_acc && s2_vld_reg && !s2_move)
    `TVTS_ASSERT_NEXT(a_no_spurious, in_acc && (cmd != CMD_TICK) && !s2_vld_reg, !s2_vld_reg)
    `TVTS_ASSERT_NEXT(a_len_interlock, cfg_acc && ((cfg_index == REG_V1_LEN) || (cfg_index == REG_V2_LEN)), !in_ready)

endmodule

`default_nettype wire

// ===== tb/sv/tb_two_voice_tone_sequencer.sv =====
`timescale 1ns / 100ps
// self-checking testbench for two_voice_tone_sequencer: predicts every tick's sample
// from its own two-voice model and checks the outputs in order; depends on tvts_pkg
// and the two_voice_tone_sequencer rtl only
module tb_two_voice_tone_sequencer;
    import tvts_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT = 1000;

    localparam logic [PHASE_W-1:0] PITCH_STEPS [48] = '{
        16'd163,  16'd173,  16'd183,  16'd194,  16'd206,  16'd218,
        16'd231,  16'd245,  16'd259,  16'd275,  16'd291,  16'd309,
        16'd327,  16'd346,  16'd367,  16'd389,  16'd412,  16'd436,
        16'd462,  16'd490,  16'd519,  16'd550,  16'd583,  16'd617,
        16'd654,  16'd693,  16'd734,  16'd778,  16'd824,  16'd873,
        16'd925,  16'd980,  16'd1038, 16'd1100, 16'd1165, 16'd1234,
        16'd1308, 16'd1386, 16'd1468, 16'd1555, 16'd1648, 16'd1746,
        16'd1849, 16'd1959, 16'd2076, 16'd2199, 16'd2330, 16'd2469
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd = '0;
    logic [ADDR_W-1:0]     addr = '0;
    logic [NOTE_W-1:0]     note = '0;
    logic                  long_pick = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SAMPLE_W-1:0]   sample;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted voice state
    logic [NOTE_W-1:0]  v1_notes [SEQ_DEPTH];
    logic [NOTE_W-1:0]  v2_notes [SEQ_DEPTH];
    logic [POS_W-1:0]   v1_pos = '0;
    logic [POS_W-1:0]   v2_pos = '0;
    logic [PHASE_W-1:0] v1_phase = '0;
    logic [PHASE_W-1:0] v2_phase = '0;
    logic [TICK_W-1:0]  v1_left = 16'd20000;
    logic [TICK_W-1:0]  v2_left = 16'd20000;

    // predicted register contents
    logic [LEN_W-1:0]   set_v1_len = 8'd101;
    logic [LEN_W-1:0]   set_v2_len = 8'd7;
    logic [TICK_W-1:0]  set_v1_long = 16'd20000;
    logic [TICK_W-1:0]  set_v1_short = 16'd10000;
    logic [TICK_W-1:0]  set_v2_ticks = 16'd40000;
    logic [NOTE_W-1:0]  set_v1_trans = 6'd24;
    logic [NOTE_W-1:0]  set_v2_trans = 6'd12;
    logic [PHASE_W-1:0] set_thresh = 16'd32000;

    logic [SAMPLE_W-1:0] sample_q [$];

    int fail_count = 0;
    int tick_count = 0;
    int write_count = 0;
    int ignored_count = 0;
    int v1_moves = 0;
    int v2_moves = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit tx_fast = 1'b0;
    bit rx_fast = 1'b0;

    two_voice_tone_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .addr      (addr),
        .note      (note),
        .long_pick (long_pick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [PHASE_W-1:0] pitch_step(input logic [NOTE_W-1:0] n,
                                                      input logic [NOTE_W-1:0] tr);
        int idx;
        idx = int'(n) - int'(tr);
        if (idx < 0 || idx > 47)
        begin
            return '0;
        end
        return PITCH_STEPS[idx];
    endfunction

    function automatic logic [POS_W-1:0] next_position(input logic [POS_W-1:0] pos,
                                                       input logic [LEN_W-1:0] len);
        int n;
        if (len == '0)
        begin
            return '0;
        end
        n = (int'(pos) + 1) % int'(len);
        if (n >= SEQ_DEPTH)
        begin
            n = 0;
        end
        return POS_W'(n);
    endfunction

    task automatic tone_update(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                               input logic [NOTE_W-1:0] n, input logic p);
        int level;
        case (c)
            CMD_WR1:
            begin
                v1_notes[a] = n;
                write_count++;
            end
            CMD_WR2:
            begin
                v2_notes[a] = n;
                write_count++;
            end
            CMD_TICK:
            begin
                v1_phase = v1_phase + pitch_step(v1_notes[v1_pos], set_v1_trans);
                v2_phase = v2_phase + pitch_step(v2_notes[v2_pos], set_v2_trans);
                v1_left = v1_left - 1'b1;
                if (v1_left == '0)
                begin
                    v1_left = p ? set_v1_long : set_v1_short;
                    v1_phase = '0;
                    v1_pos = next_position(v1_pos, set_v1_len);
                    v1_moves++;
                end
                v2_left = v2_left - 1'b1;
                if (v2_left == '0)
                begin
                    v2_left = set_v2_ticks;
                    v2_phase = '0;
                    v2_pos = next_position(v2_pos, set_v2_len);
                    v2_moves++;
                end
                level = int'(v1_phase) / 400 + ((v2_phase > set_thresh) ? 8192 : 0);
                sample_q.push_back(level[SAMPLE_W-1:0]);
                tick_count++;
            end
            default:
            begin
                ignored_count++;
            end
        endcase
    endtask

    task automatic send_request(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                                input logic [NOTE_W-1:0] n, input logic p);
        bit took;
        if (!tx_fast && burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid  <= 1'b1;
        cmd       <= c;
        addr      <= a;
        note      <= n;
        long_pick <= p;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        tone_update(c, a, n, p);
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, ADDR_W'($urandom_range(0, 127)),
                     NOTE_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sample_q.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        hold_until_drained();
        // a note write may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
        case (idx)
            REG_V1_LEN:   set_v1_len = data[LEN_W-1:0];
            REG_V2_LEN:   set_v2_len = data[LEN_W-1:0];
            REG_V1_LONG:  set_v1_long = data[TICK_W-1:0];
            REG_V1_SHORT: set_v1_short = data[TICK_W-1:0];
            REG_V2_TICKS: set_v2_ticks = data[TICK_W-1:0];
            REG_V1_TRANS: set_v1_trans = data[NOTE_W-1:0];
            REG_V2_TRANS: set_v2_trans = data[NOTE_W-1:0];
            REG_THRESH:   set_thresh = data[PHASE_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic write_settings(input int len1, input int len2, input int long1,
                                  input int short1, input int ticks2, input int trans1,
                                  input int trans2, input int thresh);
        cfg_write(REG_V1_LEN, CFG_DATA_W'(len1));
        cfg_write(REG_V2_LEN, CFG_DATA_W'(len2));
        cfg_write(REG_V1_LONG, CFG_DATA_W'(long1));
        cfg_write(REG_V1_SHORT, CFG_DATA_W'(short1));
        cfg_write(REG_V2_TICKS, CFG_DATA_W'(ticks2));
        cfg_write(REG_V1_TRANS, CFG_DATA_W'(trans1));
        cfg_write(REG_V2_TRANS, CFG_DATA_W'(trans2));
        cfg_write(REG_THRESH, CFG_DATA_W'(thresh));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(input int count);
        int i;
        int r;
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(0, 149) == 0)
            begin
                hold_until_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 62)
            begin
                send_tick();
            end
            else if (r < 80)
            begin
                send_request(CMD_WR1, $urandom_range(0, 1) ? ADDR_W'(v1_pos)
                                                           : ADDR_W'($urandom_range(0, 127)),
                             NOTE_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
            else if (r < 96)
            begin
                send_request(CMD_WR2, $urandom_range(0, 1) ? ADDR_W'(v2_pos)
                                                           : ADDR_W'($urandom_range(0, 127)),
                             NOTE_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_request(CMD_UNUSED, ADDR_W'($urandom_range(0, 127)),
                             NOTE_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // fill both note memories, then a few ticks on the reset settings
    task automatic test_reset_defaults();
        int i;
        for (i = 0; i < SEQ_DEPTH; i++)
        begin
            send_request(CMD_WR1, ADDR_W'(i), (i == 0) ? 6'd47 : NOTE_W'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            send_request(CMD_WR2, ADDR_W'(i), (i == 0) ? 6'd12 : NOTE_W'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
        end
        repeat (6) send_tick();
    endtask

    // back-to-back ticks with the output never stalled
    task automatic test_full_rate();
        wait_idle();
        write_settings(4, 3, 3, 2, 5, 0, 0, 1000);
        tx_fast = 1'b1;
        rx_fast = 1'b1;
        repeat (40) send_tick();
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    // notes below, at and past both ends of the step table
    task automatic test_table_edges();
        logic [NOTE_W-1:0] v1_edge [5];
        logic [NOTE_W-1:0] v2_edge [5];
        int k;
        v1_edge = '{6'd9, 6'd10, 6'd57, 6'd58, 6'd63};
        v2_edge = '{6'd46, 6'd47, 6'd63, 6'd0, 6'd50};
        wait_idle();
        write_settings(1, 1, 2, 3, 4, 10, 47, 300);
        for (k = 0; k < 5; k++)
        begin
            send_request(CMD_WR1, ADDR_W'(v1_pos), v1_edge[k], 1'($urandom_range(0, 1)));
            send_request(CMD_WR2, ADDR_W'(v2_pos), v2_edge[k], 1'($urandom_range(0, 1)));
            send_tick();
            if (k % 2 == 0)
            begin
                send_request(CMD_UNUSED, ADDR_W'($urandom_range(0, 127)),
                             NOTE_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
            send_tick();
        end
    endtask

    // zero length and lengths past the memory depth
    task automatic test_wrap_cases();
        wait_idle();
        write_settings(0, 255, 3, 4, 2, 20, 5, 5000);
        run_mix(100);
        wait_idle();
        write_settings(200, 129, 1, 2, 1, 63, 63, 12345);
        run_mix(100);
    endtask

    task automatic test_random_mix();
        wait_idle();
        write_settings(4, 3, 5, 2, 7, 0, 0, 0);
        run_mix(100);
        wait_idle();
        write_settings(128, 128, 1, 1, 1, 47, 47, 20000);
        run_mix(100);
        wait_idle();
        write_settings($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8),
                       $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 30),
                       $urandom_range(0, 30), $urandom_range(0, 65535));
        run_mix(100);
    endtask

    // zero reloads wrap the counters, so this runs last
    task automatic test_extreme_reloads();
        wait_idle();
        write_settings(128, 1, 65535, 0, 0, 0, 12, 65535);
        run_mix(100);
    endtask

    initial
    begin : rx_stall
        int left;
        logic [31:0] pattern;
        left = 0;
        pattern = '1;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                pattern = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : ($urandom() | 32'h1);
                left = 32;
            end
            left--;
            out_ready <= rx_fast ? 1'b1 : pattern[left];
        end
    end

    initial
    begin : sample_check
        bit fire;
        logic [SAMPLE_W-1:0] got;
        logic [SAMPLE_W-1:0] want;
        forever
        begin
            @(negedge clk);
            fire = (out_valid === 1'b1) && (out_ready === 1'b1);
            got = sample;
            @(posedge clk);
            if (fire)
            begin
                if (sample_q.size() == 0)
                begin
                    $display("%0t: unexpected sample, expected none, actual %0d", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: sample mismatch, expected %0d, actual %0d",
                                 $time, want, got);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        forever
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_full_rate();
        test_table_edges();
        test_wrap_cases();
        test_random_mix();
        test_extreme_reloads();
        wait_idle();
        $display("covered %0d ticks, %0d note writes, %0d unused commands over all settings",
                 tick_count, write_count, ignored_count);
        $display("voice one advanced %0d times, voice two %0d times, %0d mismatches",
                 v1_moves, v2_moves, fail_count);
        if (fail_count == 0 && sample_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tvts_pkg.sv
hdl/tvts_voice.sv
hdl/two_voice_tone_sequencer.sv
tb/sv/tb_two_voice_tone_sequencer.sv
